// ----- rtl/ret_pkg.sv -----
// REM episode trigger: shared types, constants and register codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ret_pkg;

  // Default width of sample timestamps and run durations
  localparam int unsigned TIME_BITS_DEF = 48;

  // Width of each threshold register
  localparam int unsigned CFG_W = 48;

  // Register index width on the configuration port
  localparam int unsigned CFG_IDX_W = 2;

  // Episode counter: width, saturation value, episode that arms the first offset
  localparam int unsigned EP_W = 3;
  localparam logic [EP_W-1:0] EPISODE_CAP   = 3'd4;
  localparam logic [EP_W-1:0] THIRD_EPISODE = 3'd3;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_REM_DURATION    = 2'd0,
    REG_THIRD_EPISODE_DELAY = 2'd1,
    REG_LATER_EPISODE_DELAY = 2'd2
  } ret_reg_e;

  // Threshold set handed to the decision logic
  typedef struct packed {
    logic [CFG_W-1:0] min_rem_duration;
    logic [CFG_W-1:0] third_episode_delay;
    logic [CFG_W-1:0] later_episode_delay;
  } ret_cfg_t;

endpackage

// ----- rtl/ret_cfg.sv -----
// REM episode trigger: threshold register file behind the write channel.
// Depends on ret_pkg for register codes and the threshold struct.
`timescale 1ns / 1ps

module ret_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ret_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ret_pkg::CFG_W-1:0]      cfg_data_i,
  output ret_pkg::ret_cfg_t              cfg_o
);
  import ret_pkg::*;

  ret_cfg_t cfg_d, cfg_q;

  // Always ready; a write is registered into cfg_q
  assign cfg_ready_o = 1'b1;

  // Decode the index; unknown indexes leave the registers alone
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MIN_REM_DURATION:    cfg_d.min_rem_duration    = cfg_data_i;
        REG_THIRD_EPISODE_DELAY: cfg_d.third_episode_delay = cfg_data_i;
        REG_LATER_EPISODE_DELAY: cfg_d.later_episode_delay = cfg_data_i;
        default:                 cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/ret_core.sv -----
// REM episode trigger: run tracking, episode counting and activation state.
// Depends on ret_pkg; fed from the input register, drives the result register.
`timescale 1ns / 1ps

module ret_core #(
  parameter int unsigned TIME_BITS = ret_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,      // one sample processed this cycle
  input  logic [TIME_BITS-1:0] ts_i,
  input  logic                 rem_i,
  input  ret_pkg::ret_cfg_t    cfg_i,
  output logic                 active_o     // active flag after this sample
);
  import ret_pkg::*;

  localparam int unsigned CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  logic                 rem_seen_d, rem_seen_q;
  logic [TIME_BITS-1:0] start_d, start_q;
  logic [TIME_BITS-1:0] dur_d, dur_q;
  logic                 counted_d, counted_q;
  logic [EP_W-1:0]      ep_cnt_d, ep_cnt_q;
  logic                 active_d, active_q;

  logic [TIME_BITS-1:0] elapsed;
  logic [CMP_W-1:0]     elapsed_x;
  logic [EP_W-1:0]      ep_next;
  logic                 over_min;
  logic                 reach_third;
  logic                 reach_later;

  // Duration since run start, wrapping at the timestamp width
  assign elapsed   = ts_i - start_q;
  assign elapsed_x = CMP_W'(elapsed);

  // Threshold compares run in parallel off the fresh duration
  assign over_min    = elapsed_x >  CMP_W'(cfg_i.min_rem_duration);
  assign reach_third = elapsed_x >= CMP_W'(cfg_i.third_episode_delay);
  assign reach_later = elapsed_x >= CMP_W'(cfg_i.later_episode_delay);

  // Count the run once, saturating at the cap
  assign ep_next = (!counted_q && (ep_cnt_q < EPISODE_CAP)) ? ep_cnt_q + 1'b1 : ep_cnt_q;

  // Next state for one sample
  always_comb begin
    rem_seen_d = rem_seen_q;
    start_d    = start_q;
    dur_d      = dur_q;
    counted_d  = counted_q;
    ep_cnt_d   = ep_cnt_q;
    active_d   = active_q;
    if (!rem_i) begin
      // Leaving REM: drop run state, keep the episode count
      if (rem_seen_q) begin
        rem_seen_d = 1'b0;
        active_d   = 1'b0;
        counted_d  = 1'b0;
        dur_d      = '0;
      end
    end else if (!rem_seen_q) begin
      // First REM sample opens a run
      rem_seen_d = 1'b1;
      start_d    = ts_i;
      dur_d      = '0;
    end else begin
      dur_d = elapsed;
      if (over_min) begin
        counted_d = 1'b1;
        ep_cnt_d  = ep_next;
        if (ep_next == THIRD_EPISODE) begin
          if (reach_third) active_d = 1'b1;
        end else if (ep_next > THIRD_EPISODE) begin
          if (reach_later) active_d = 1'b1;
        end
      end
    end
  end

  // Advance state only on a processed sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_seen_q <= 1'b0;
      start_q    <= '0;
      dur_q      <= '0;
      counted_q  <= 1'b0;
      ep_cnt_q   <= '0;
      active_q   <= 1'b0;
    end else if (step_i) begin
      rem_seen_q <= rem_seen_d;
      start_q    <= start_d;
      dur_q      <= dur_d;
      counted_q  <= counted_d;
      ep_cnt_q   <= ep_cnt_d;
      active_q   <= active_d;
    end
  end

  assign active_o = active_d;

  // Episode counter never passes the cap
  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ep_cnt_q <= EPISODE_CAP)
    else $error("episode count above cap");

  // Active only inside a run that reached the third episode
  a_active_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (rem_seen_q && counted_q && ep_cnt_q >= THIRD_EPISODE))
    else $error("active outside a qualifying run");

  // A counted run has at least one episode on record
  a_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    counted_q |-> (rem_seen_q && ep_cnt_q != '0))
    else $error("counted run without episode");

  // Outside a run the duration stays cleared
  a_idle_dur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rem_seen_q |-> (dur_q == '0))
    else $error("duration held outside a run");

  // The episode count never decreases
  a_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |=> (ep_cnt_q >= $past(ep_cnt_q)))
    else $error("episode count dropped");

endmodule

// ----- rtl/rem_episode_trigger_top.sv -----
// REM episode trigger: top level with input register, result register and ports.
// Depends on ret_pkg, ret_cfg and ret_core.
//
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: timestamp_ms; tuser: stage_is_rem
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: trigger_active in bit 0
//  cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// One sample per clock while the result side drains: an item is captured in the input
// register, then the run logic (one subtract, three compares) updates state and loads the
// result register, which drives tvalid; an item thus passes the input register and then
// the result register before its result can be accepted.
// Reset (rst_ni low, asynchronous) clears both pipeline stages, state and thresholds.
// A stalled result holds both stages; the input side keeps taking items while
// the input register is empty or moving on.
`timescale 1ns / 1ps

module rem_episode_trigger_top #(
  parameter int unsigned TIME_BITS = ret_pkg::TIME_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Samples in
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [((TIME_BITS+7)/8)*8-1:0] s_axis_tdata,   // [TIME_BITS-1:0] timestamp_ms
  input  logic                           s_axis_tuser,   // [0] stage_is_rem
  // Results out
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,   // [0] trigger_active
  // Threshold writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [ret_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ret_pkg::CFG_W-1:0]      cfg_data_i
);
  import ret_pkg::*;

  ret_cfg_t             cfg;
  logic                 advance;
  logic                 in_vld_q;
  logic [TIME_BITS-1:0] ts_q;
  logic                 rem_q;
  logic                 out_vld_q;
  logic                 active_q;
  logic                 active;
  logic                 step;

  // Thresholds
  ret_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Pipeline moves when the result slot is free or being drained
  assign advance       = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || advance;
  assign step          = in_vld_q && advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      ts_q  <= s_axis_tdata[TIME_BITS-1:0];
      rem_q <= s_axis_tuser;
    end
  end

  // Run and episode logic
  ret_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .ts_i     (ts_q),
    .rem_i    (rem_q),
    .cfg_i    (cfg),
    .active_o (active)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      active_q <= active;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {7'b0, active_q};

endmodule
